/* hdl/ihex_pkg.sv */
// Shared types, codes and constants of the hex record parser.
`default_nettype none
package ihex_pkg;

   // Fixed geometry and gates of the address map
   localparam logic [32:0] IMAGE_BYTES = 33'd16777216;
   localparam logic [24:0] FLASH_GATE  = 25'd1048576;
   localparam logic [10:0] BLOCK_GATE  = 11'd1024;
   // Upper half of the flash window offset
   localparam logic [15:0] FLASH_PAGE  = 16'h6000;
   localparam logic [7:0]  COLON       = 8'h3A;
   localparam logic [7:0]  NEWLINE     = 8'h0A;
   // Largest parse position: colon, eight header characters, 255 data bytes and the first checksum character
   localparam logic [9:0]  FP_MAX      = 10'd520;

   // Configuration port
   localparam int unsigned CSR_DATA_W = 25;
   localparam logic CSR_CODE_BYTES  = 1'b0;
   localparam logic CSR_BLOCK_BYTES = 1'b1;

   // Record types
   localparam logic [7:0] REC_DATA    = 8'h00;
   localparam logic [7:0] REC_EOF     = 8'h01;
   localparam logic [7:0] REC_EXT_SEG = 8'h02;
   localparam logic [7:0] REC_EXT_LIN = 8'h04;

   // Result kinds
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // Error causes
   localparam logic [2:0] CAUSE_NONE     = 3'd0;
   localparam logic [2:0] CAUSE_NO_COLON = 3'd1;
   localparam logic [2:0] CAUSE_DIGIT    = 3'd2;
   localparam logic [2:0] CAUSE_SHORT    = 3'd3;
   localparam logic [2:0] CAUSE_RANGE    = 3'd4;
   localparam logic [2:0] CAUSE_CHECKSUM = 3'd5;

   typedef struct packed {
      logic [7:0] text_char;
      logic       new_file;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [23:0] write_address;
      logic [7:0]  write_byte;
      logic [31:0] data_byte_total;
      logic [2:0]  error_cause;
   } rsp_item_type;

   typedef struct packed {
      logic         hit;
      rsp_item_type item;
   } parse_out_type;

   // Decode one ASCII hex digit: bit 4 flags a valid digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/intel_hex_record_parser_core.sv */
// Top level of the hex record parser: input register, decoder and result register.
`default_nettype none
// Takes one text character per transfer and sustains one character per clock
// while the result channel does not stall. A character waits in the input
// register until the result register can take it, is decoded against the record
// state and lands in the result register at the next edge; characters that cause
// no result pass through the same two stages. The input side stalls only while
// both the input register and an unread result are full. The user must write
// configuration through the csr port only while no character is in flight; the
// block itself does not enforce it.
module intel_hex_record_parser_core
   import ihex_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_item,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff;
   logic          space;
   logic          advance;
   parse_out_type result;

   // Move the held character on whenever the result register can take it
   assign advance   = in_valid_ff && space;
   assign req_ready = !in_valid_ff || space;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   ihex_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .item      (in_item_ff),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   ihex_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .space     (space),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

/* hdl/ihex_parse.sv */
// Parse state, configuration registers and per-character record decoding.
`default_nettype none
module ihex_parse
   import ihex_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  req_item_type          item,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output parse_out_type         result
);

   logic [24:0] code_bytes_ff;
   logic [10:0] block_bytes_ff;

   logic [9:0]  fp_ff, fp_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sum_ff, sum_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic [15:0] payload_ff, payload_in;
   logic [31:0] base_ff, base_in;
   logic [7:0]  done_ff, done_in;
   logic [31:0] total_ff, total_in;
   logic        halted_ff, halted_in;
   logic        skip_ff, skip_in;

   logic [7:0]  c;
   logic [4:0]  hexv;
   logic [3:0]  nib;
   logic [9:0]  d;
   logic [9:0]  len_end;
   logic        is_ext;
   logic [7:0]  data_b;
   logic [7:0]  sum_next;
   logic [32:0] range_sum;
   logic [32:0] total_sum;
   logic [15:0] page_delta;
   logic        qualify;
   logic        clear_rec;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         code_bytes_ff  <= '0;
         block_bytes_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CODE_BYTES:  code_bytes_ff  <= csr_wdata[24:0];
            CSR_BLOCK_BYTES: block_bytes_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // Parse state: advance once per character transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff      <= '0;
         len_ff     <= '0;
         offset_ff  <= '0;
         type_ff    <= '0;
         sum_ff     <= '0;
         nibble_ff  <= '0;
         payload_ff <= '0;
         base_ff    <= '0;
         done_ff    <= '0;
         total_ff   <= '0;
         halted_ff  <= 1'b0;
         skip_ff    <= 1'b0;
      end else if (step_en) begin
         fp_ff      <= fp_in;
         len_ff     <= len_in;
         offset_ff  <= offset_in;
         type_ff    <= type_in;
         sum_ff     <= sum_in;
         nibble_ff  <= nibble_in;
         payload_ff <= payload_in;
         base_ff    <= base_in;
         done_ff    <= done_in;
         total_ff   <= total_in;
         halted_ff  <= halted_in;
         skip_ff    <= skip_in;
      end
   end

   // Decode one character against the current record
   always_comb begin
      fp_in      = fp_ff;
      len_in     = len_ff;
      offset_in  = offset_ff;
      type_in    = type_ff;
      sum_in     = sum_ff;
      nibble_in  = nibble_ff;
      payload_in = payload_ff;
      base_in    = base_ff;
      done_in    = done_ff;
      total_in   = total_ff;
      halted_in  = halted_ff;
      skip_in    = skip_ff;
      result     = '0;
      clear_rec  = 1'b0;

      c    = item.text_char;
      hexv = hex_value(c);
      nib  = hexv[3:0];

      // A new file drops everything before this character is used
      if (item.new_file) begin
         fp_in      = '0;
         len_in     = '0;
         offset_in  = '0;
         type_in    = '0;
         sum_in     = '0;
         nibble_in  = '0;
         payload_in = '0;
         done_in    = '0;
         skip_in    = 1'b0;
         base_in    = '0;
         total_in   = '0;
         halted_in  = 1'b0;
      end

      d          = fp_in - 10'd1;
      is_ext     = (type_in == REC_EXT_SEG || type_in == REC_EXT_LIN) && len_in == 8'd2;
      len_end    = {1'b0, len_in, 1'b0} + 10'd9;
      data_b     = {nibble_in, nib};
      sum_next   = sum_in + data_b;
      range_sum  = 33'(offset_in) + 33'(base_in) + 33'(len_in);
      total_sum  = 33'(total_in) + 33'(len_in);
      page_delta = payload_in - FLASH_PAGE;
      qualify    = code_bytes_ff > FLASH_GATE && block_bytes_ff >= BLOCK_GATE &&
                   payload_in >= FLASH_PAGE &&
                   {page_delta, 16'h0000} < 32'(code_bytes_ff);

      if (halted_in) begin
         // hold until a new file
      end else if (skip_in) begin
         if (c == NEWLINE) begin
            skip_in = 1'b0;
         end
      end else if (fp_in == '0) begin
         if (c != COLON) begin
            clear_rec                = 1'b1;
            halted_in                = 1'b1;
            result.hit               = 1'b1;
            result.item.result_kind  = KIND_ERROR;
            result.item.error_cause  = CAUSE_NO_COLON;
         end else begin
            len_in     = '0;
            offset_in  = '0;
            type_in    = '0;
            sum_in     = '0;
            nibble_in  = '0;
            payload_in = '0;
            done_in    = '0;
            fp_in      = 10'd1;
         end
      end else if (c == NEWLINE) begin
         clear_rec               = 1'b1;
         halted_in               = 1'b1;
         result.hit              = 1'b1;
         result.item.result_kind = KIND_ERROR;
         result.item.error_cause = CAUSE_SHORT;
      end else if (d >= 10'd8 && type_in != REC_DATA && !is_ext) begin
         // Unknown record body: count characters only and accept the record at its end
         fp_in = fp_in + 10'd1;
         if (d == len_end) begin
            fp_in                   = '0;
            skip_in                 = 1'b1;
            result.hit              = 1'b1;
            result.item.result_kind = KIND_ACCEPT;
         end
      end else if (!hexv[4]) begin
         if (d >= 10'd8 && is_ext) begin
            // Drop a malformed extended record quietly
            fp_in   = '0;
            skip_in = 1'b1;
         end else begin
            clear_rec               = 1'b1;
            halted_in               = 1'b1;
            result.hit              = 1'b1;
            result.item.result_kind = KIND_ERROR;
            result.item.error_cause = CAUSE_DIGIT;
         end
      end else begin
         fp_in = fp_in + 10'd1;
         if (!d[0]) begin
            nibble_in = nib;
         end else begin
            sum_in = sum_next;
            if (d == 10'd1) begin
               len_in = data_b;
            end else if (d == 10'd3) begin
               offset_in = {data_b, 8'h00};
            end else if (d == 10'd5) begin
               offset_in[7:0] = data_b;
            end else if (d == 10'd7) begin
               // Record type known: check range, end of file, count data bytes
               type_in = data_b;
               if (range_sum >= IMAGE_BYTES) begin
                  clear_rec               = 1'b1;
                  halted_in               = 1'b1;
                  result.hit              = 1'b1;
                  result.item.result_kind = KIND_ERROR;
                  result.item.error_cause = CAUSE_RANGE;
               end else if (data_b == REC_EOF) begin
                  clear_rec               = 1'b1;
                  halted_in               = 1'b1;
                  result.hit              = 1'b1;
                  result.item.result_kind = KIND_END;
               end else if (data_b == REC_DATA) begin
                  total_in = total_sum[32] ? '1 : total_sum[31:0];
               end
            end else if (is_ext) begin
               if (d == 10'd9) begin
                  payload_in = {data_b, 8'h00};
               end else if (d == 10'd11) begin
                  payload_in[7:0] = data_b;
               end else begin
                  fp_in   = '0;
                  skip_in = 1'b1;
                  if (sum_next == 8'h00) begin
                     if (type_in == REC_EXT_SEG) begin
                        base_in = {12'h000, payload_in, 4'h0};
                     end else if (qualify) begin
                        base_in = {page_delta, 16'h0000};
                     end else begin
                        base_in = {payload_in, 16'h0000};
                     end
                     result.hit              = 1'b1;
                     result.item.result_kind = KIND_ACCEPT;
                  end
               end
            end else if (done_in < len_in) begin
               result.hit                = 1'b1;
               result.item.result_kind   = KIND_DATA;
               result.item.write_address = 24'(offset_in) + base_in[23:0] + 24'(done_in);
               result.item.write_byte    = data_b;
               done_in                   = done_in + 8'd1;
            end else if (sum_next != 8'h00) begin
               clear_rec               = 1'b1;
               halted_in               = 1'b1;
               result.hit              = 1'b1;
               result.item.result_kind = KIND_ERROR;
               result.item.error_cause = CAUSE_CHECKSUM;
            end else begin
               fp_in                   = '0;
               skip_in                 = 1'b1;
               result.hit              = 1'b1;
               result.item.result_kind = KIND_ACCEPT;
            end
         end
      end

      // Drop the record after an error or the end record
      if (clear_rec) begin
         fp_in      = '0;
         len_in     = '0;
         offset_in  = '0;
         type_in    = '0;
         sum_in     = '0;
         nibble_in  = '0;
         payload_in = '0;
         done_in    = '0;
         skip_in    = 1'b0;
      end

      result.item.data_byte_total = total_in;
   end

`ifndef SYNTHESIS
   a_fp_bound: assert property (@(posedge clock) disable iff (reset) fp_ff <= FP_MAX)
      else $error("parse position out of range");
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      step_en && result.hit &&
      (result.item.result_kind == KIND_ERROR || result.item.result_kind == KIND_END)
      |=> halted_ff)
      else $error("error or end record did not halt the parse");
   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff && !item.new_file |-> !result.hit)
      else $error("result produced while halted");
   a_cause_kind: assert property (@(posedge clock) disable iff (reset)
      result.hit |-> ((result.item.result_kind == KIND_ERROR) ==
                      (result.item.error_cause != CAUSE_NONE)))
      else $error("error cause does not match result kind");
`endif

endmodule
`default_nettype wire

/* hdl/ihex_rsp_reg.sv */
// Result register between the decoder and the result channel.
`default_nettype none
module ihex_rsp_reg
   import ihex_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  parse_out_type result,
   output logic          space,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_item_type  rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   // Free when empty or when the held result leaves this cycle
   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = result.hit;
         item_in  = result.item;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |-> !load)
      else $error("held result overwritten");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(item_ff))
      else $error("stalled result changed");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff == $past(result.hit))
      else $error("result valid does not follow decoder");
`endif

endmodule
`default_nettype wire
